// File: src/lrm_pkg.sv
// shared types and constants of the lift run time and rise meter
package lrm_pkg;

    localparam int TICK_W   = 32;
    localparam int CODE_W   = 4;
    localparam int MASK_W   = 16;
    localparam int PERIOD_W = 16;
    localparam int LIFTS_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // dividend is accumulator plus elapsed time, one bit wider than a tick
    localparam int DIVIDEND_W = TICK_W + 1;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [MASK_W-1:0]   MOTION_MASK_RESET = '0;
    localparam logic [CODE_W-1:0]   RISING_CODE_RESET = CODE_W'(1);
    localparam logic [PERIOD_W-1:0] RISE_PERIOD_RESET = PERIOD_W'(3000);
    localparam logic [CODE_W-1:0]   IDLE_CODE         = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISING_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_PERIOD = 2'd2;

    typedef struct packed {
        logic [TICK_W-1:0] tick_ms;
        logic [CODE_W-1:0] state_code;
        logic              motor_run;
        logic              valve_open;
        logic              ack_event;
        logic              clear_rise;
    } sample_t;

    typedef struct packed {
        logic [LIFTS_W-1:0] lifts_added;
        logic [TICK_W-1:0]  runs_total;
        logic [TICK_W-1:0]  run_ms_sum;
        logic [TICK_W-1:0]  run_ms_now;
        logic               run_ended;
        logic [TICK_W-1:0]  finished_run_ms;
        logic               event_pending;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic stat;
        logic step;
        logic fin;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_STAT = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

endpackage

// File: src/lrm_if.sv
// stream interfaces for poll samples and meter results
interface lrm_in_if;
    logic                      valid;
    logic                      ready;
    logic [lrm_pkg::TICK_W-1:0] tick_ms;
    logic [lrm_pkg::CODE_W-1:0] state_code;
    logic                      motor_run;
    logic                      valve_open;
    logic                      ack_event;
    logic                      clear_rise;

    modport source (output valid, tick_ms, state_code, motor_run, valve_open,
                    ack_event, clear_rise, input ready);
    modport sink (input valid, tick_ms, state_code, motor_run, valve_open,
                  ack_event, clear_rise, output ready);
endinterface

interface lrm_out_if;
    logic                        valid;
    logic                        ready;
    logic [lrm_pkg::LIFTS_W-1:0] lifts_added;
    logic [lrm_pkg::TICK_W-1:0]  runs_total;
    logic [lrm_pkg::TICK_W-1:0]  run_ms_sum;
    logic [lrm_pkg::TICK_W-1:0]  run_ms_now;
    logic                        run_ended;
    logic [lrm_pkg::TICK_W-1:0]  finished_run_ms;
    logic                        event_pending;

    modport source (output valid, lifts_added, runs_total, run_ms_sum, run_ms_now,
                    run_ended, finished_run_ms, event_pending, input ready);
    modport sink (input valid, lifts_added, runs_total, run_ms_sum, run_ms_now,
                  run_ended, finished_run_ms, event_pending, output ready);
endinterface

// File: src/lift_run_time_and_rise_meter.sv
// top level of the lift run time and rise meter
// a sample goes from idle through the prepare and statistics states to the finish state;
// when the rise accumulator is divided by the period, the 33-step serial divider runs
// between statistics and finish; a new sample is taken only in idle, once the last has finished
// a finished result waits in the output register while the next sample is taken
// reset: asynchronous active low, clears all statistics and restores register defaults
module lift_run_time_and_rise_meter (
    input  logic                           clk,
    input  logic                           rst_n,
    lrm_in_if.sink                         in_ch,
    lrm_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [lrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lrm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lrm_pkg::*;

    sample_t sample;
    result_t result;
    cmd_t    cmd;
    status_t status;
    logic    in_ready;
    logic    out_valid;

    // gather the input transfer payload into one word
    assign sample.tick_ms       = in_ch.tick_ms;
    assign sample.state_code    = in_ch.state_code;
    assign sample.motor_run     = in_ch.motor_run;
    assign sample.valve_open    = in_ch.valve_open;
    assign sample.ack_event     = in_ch.ack_event;
    assign sample.clear_rise    = in_ch.clear_rise;
    assign in_ch.ready          = in_ready;

    // sequencer: idle, prepare differences, update statistics, divide, finish
    lrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // run statistics, rise accumulator and the result register
    lrm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .result    (result)
    );

    // result transfer
    assign out_ch.valid           = out_valid;
    assign out_ch.lifts_added     = result.lifts_added;
    assign out_ch.runs_total      = result.runs_total;
    assign out_ch.run_ms_sum      = result.run_ms_sum;
    assign out_ch.run_ms_now      = result.run_ms_now;
    assign out_ch.run_ended       = result.run_ended;
    assign out_ch.finished_run_ms = result.finished_run_ms;
    assign out_ch.event_pending   = result.event_pending;

endmodule

// File: src/lrm_ctrl.sv
// sequencing state machine of the meter
module lrm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lrm_pkg::status_t status,
    output lrm_pkg::cmd_t    cmd
);
    import lrm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_STAT;
            end
            S_STAT:
            begin
                cmd.stat   = 1'b1;
                state_next = status.need_div ? S_DIV : S_FIN;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/lrm_dp.sv
// datapath: run statistics, rise accumulator, serial divider, result register
module lrm_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lrm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lrm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  lrm_pkg::sample_t                  sample,
    input  lrm_pkg::cmd_t                     cmd,
    output lrm_pkg::status_t                  status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lrm_pkg::result_t                  result
);
    import lrm_pkg::*;

    // configuration
    logic [MASK_W-1:0]   motion_mask_reg;
    logic [CODE_W-1:0]   rising_code_reg;
    logic [PERIOD_W-1:0] rise_period_reg;

    // persistent state
    logic [CODE_W-1:0] prev_state_reg,   prev_state_next;
    logic [TICK_W-1:0] run_start_reg,    run_start_next;
    logic [TICK_W-1:0] runs_reg,         runs_next;
    logic [TICK_W-1:0] fsum_reg,         fsum_next;
    logic [TICK_W-1:0] running_reg,      running_next;
    logic [TICK_W-1:0] acc_reg,          acc_next;
    logic [TICK_W-1:0] prev_tick_reg,    prev_tick_next;
    logic              prev_qual_reg,    prev_qual_next;
    logic              seen_reg,         seen_next;
    logic              sticky_reg,       sticky_next;

    // per sample working registers
    sample_t           smp_reg;
    logic [TICK_W-1:0] run_diff_reg;
    logic [TICK_W-1:0] elapsed_reg;
    logic [TICK_W-1:0] finished_reg,     finished_next;
    logic              ended_reg,        ended_next;
    logic              div_en_reg,       div_en_next;

    // divider
    logic [DIVIDEND_W-1:0] quo_reg,      quo_next;
    logic [PERIOD_W-1:0]   rem_reg,      rem_next;
    logic [DIV_CNT_W-1:0]  cnt_reg,      cnt_next;
    logic [PERIOD_W-1:0]   period_eff;
    logic [PERIOD_W:0]     rem_shift;
    logic [PERIOD_W:0]     rem_sub;
    logic                  quo_bit;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t result_reg;

    logic moving_now;
    logic moving_prev;
    logic qualified;
    logic [LIFTS_W-1:0] lifts;

    assign period_eff = (rise_period_reg == '0) ? PERIOD_W'(1) : rise_period_reg;
    assign moving_now  = motion_mask_reg[smp_reg.state_code];
    assign moving_prev = motion_mask_reg[prev_state_reg];
    assign qualified   = (smp_reg.state_code == rising_code_reg) && smp_reg.motor_run
                         && !smp_reg.valve_open;

    // restoring divider step
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign rem_sub   = rem_shift - {1'b0, period_eff};
    assign quo_bit   = (rem_shift >= {1'b0, period_eff});

    assign lifts = (|quo_reg[DIVIDEND_W-1:LIFTS_W]) ? '1 : quo_reg[LIFTS_W-1:0];

    assign status.need_div = div_en_next;
    assign status.div_last = (cnt_reg == DIV_CNT_W'(1));
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_mask_reg <= MOTION_MASK_RESET;
            rising_code_reg <= RISING_CODE_RESET;
            rise_period_reg <= RISE_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MOTION_MASK: motion_mask_reg <= cfg_data[MASK_W-1:0];
                CFG_RISING_CODE: rising_code_reg <= cfg_data[CODE_W-1:0];
                CFG_RISE_PERIOD: rise_period_reg <= cfg_data[PERIOD_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        prev_state_next = prev_state_reg;
        run_start_next  = run_start_reg;
        runs_next       = runs_reg;
        fsum_next       = fsum_reg;
        running_next    = running_reg;
        acc_next        = acc_reg;
        prev_tick_next  = prev_tick_reg;
        prev_qual_next  = prev_qual_reg;
        seen_next       = seen_reg;
        sticky_next     = sticky_reg;
        finished_next   = finished_reg;
        ended_next      = ended_reg;
        div_en_next     = div_en_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cmd.load)
        begin
            if (sample.ack_event)
            begin
                sticky_next = 1'b0;
            end
            if (sample.clear_rise)
            begin
                acc_next = '0;
            end
        end

        if (cmd.stat)
        begin
            finished_next = '0;
            ended_next    = 1'b0;
            if (!moving_prev && moving_now)
            begin
                run_start_next = smp_reg.tick_ms;
                running_next   = '0;
                runs_next      = runs_reg + TICK_W'(1);
            end
            else if (moving_prev && !moving_now)
            begin
                finished_next = run_diff_reg;
                fsum_next     = fsum_reg + run_diff_reg;
                running_next  = '0;
                ended_next    = 1'b1;
            end
            else if (moving_now)
            begin
                running_next = run_diff_reg;
            end
            if (smp_reg.state_code != prev_state_reg)
            begin
                sticky_next = 1'b1;
            end
            prev_state_next = smp_reg.state_code;
            div_en_next = seen_reg && prev_qual_reg && (elapsed_reg != '0);
            quo_next    = {1'b0, acc_reg} + {1'b0, elapsed_reg};
            rem_next    = '0;
            cnt_next    = DIV_CNT_W'(DIV_STEPS);
        end

        if (cmd.step)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], quo_bit};
            rem_next = quo_bit ? rem_sub[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
        end

        if (cmd.fin)
        begin
            if (seen_reg)
            begin
                if (div_en_reg)
                begin
                    acc_next = TICK_W'(rem_reg);
                    if (quo_reg != '0)
                    begin
                        sticky_next = 1'b1;
                    end
                end
                if (!qualified)
                begin
                    acc_next = '0;
                end
            end
            seen_next      = 1'b1;
            prev_tick_next = smp_reg.tick_ms;
            prev_qual_next = qualified;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_state_reg <= IDLE_CODE;
            run_start_reg  <= '0;
            runs_reg       <= '0;
            fsum_reg       <= '0;
            running_reg    <= '0;
            acc_reg        <= '0;
            prev_tick_reg  <= '0;
            prev_qual_reg  <= 1'b0;
            seen_reg       <= 1'b0;
            sticky_reg     <= 1'b0;
            div_en_reg     <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prev_state_reg <= prev_state_next;
            run_start_reg  <= run_start_next;
            runs_reg       <= runs_next;
            fsum_reg       <= fsum_next;
            running_reg    <= running_next;
            acc_reg        <= acc_next;
            prev_tick_reg  <= prev_tick_next;
            prev_qual_reg  <= prev_qual_next;
            seen_reg       <= seen_next;
            sticky_reg     <= sticky_next;
            div_en_reg     <= div_en_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            smp_reg <= sample;
        end
        if (cmd.prep)
        begin
            run_diff_reg <= smp_reg.tick_ms - run_start_reg;
            elapsed_reg  <= smp_reg.tick_ms - prev_tick_reg;
        end
        finished_reg <= finished_next;
        ended_reg    <= ended_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        if (cmd.fin)
        begin
            result_reg.lifts_added     <= (seen_reg && div_en_reg) ? lifts : '0;
            result_reg.runs_total      <= runs_reg;
            result_reg.run_ms_sum      <= fsum_reg;
            result_reg.run_ms_now      <= running_reg;
            result_reg.run_ended       <= ended_reg;
            result_reg.finished_run_ms <= finished_reg;
            result_reg.event_pending   <= sticky_next;
        end
    end

`ifndef SYNTHESIS
    // a divider step never leaves a remainder at or above the period
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> (rem_reg < period_eff))
        else $error("divider remainder out of range");

    // finishing a sample always presents a result
    a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> out_valid_reg)
        else $error("result not presented after finish");

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");

    // a finished run leaves no run in progress
    a_end_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fin && ended_reg) |-> (running_reg == '0))
        else $error("run length not cleared at run end");
`endif

endmodule
